[rtl/tbwu_pkg.sv]
// ----------------------------------------------------------------------------
// tbwu_pkg
// Types and constants for the TDC bank word unpacker: payload structs,
// parse states, header codes and data word types.
// ----------------------------------------------------------------------------
package tbwu_pkg;

  typedef struct packed {
    logic [31:0] data_word;
    logic        first_word;
    logic        last_word;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  board;
    logic [6:0]  channel;
    logic [27:0] epoch;
    logic [8:0]  fine_code;
    logic        rise;
    logic [10:0] coarse_code;
    logic        mismatch_error;
    logic [27:0] sum_epoch;
    logic [10:0] sum_coarse;
    logic [31:0] bank_number;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } result_pair_t;

  typedef enum logic [1:0] {
    PS_SEARCH = 2'd0,
    PS_BOARD  = 2'd1,
    PS_CTS    = 2'd2,
    PS_ENDED  = 2'd3
  } parse_state_t;

  localparam logic        KIND_HIT      = 1'b0;
  localparam logic        KIND_SUMMARY  = 1'b1;

  localparam logic [15:0] HDR_CTS       = 16'hC001;
  localparam logic [15:0] HDR_BOARD_MSK = 16'hFFFC;
  localparam logic [15:0] HDR_BOARD     = 16'h0100;
  localparam logic [15:0] HDR_END       = 16'h5555;

  localparam logic [2:0]  WT_EPOCH      = 3'd3;
  localparam logic [2:0]  WT_HIT        = 3'd4;

  localparam logic [7:0]  HEADER_WORDS_RST = 8'd6;
  localparam logic [7:0]  POS_MAX          = 8'hFF;

endpackage

[rtl/tbwu_decode.sv]
// ----------------------------------------------------------------------------
// tbwu_decode
// Per-bank parse state and word decode. Produces up to two results for the
// word at its input and updates the state when the word advances.
// ----------------------------------------------------------------------------
module tbwu_decode (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  tbwu_pkg::in_item_t     item,
  input  logic [7:0]             header_words,
  output tbwu_pkg::result_pair_t pair
);

  tbwu_pkg::parse_state_t parse_state, parse_state_next;
  logic [7:0]  word_position, word_position_next;
  logic [7:0]  words_left, words_left_next;
  logic [1:0]  current_board, current_board_next;
  logic [27:0] current_epoch, current_epoch_next;
  logic [27:0] ref_epoch, ref_epoch_next;
  logic [10:0] ref_coarse, ref_coarse_next;
  logic        bank_error, bank_error_next;
  logic [31:0] bank_count, bank_count_next;

  tbwu_pkg::parse_state_t st_b;
  logic [7:0]  pos_b, left_b;
  logic [1:0]  board_b;
  logic [27:0] epoch_b, ref_epoch_b;
  logic [10:0] ref_coarse_b;
  logic        err_b;

  logic [31:0] w;
  logic [2:0]  wtype;
  logic [6:0]  chan;
  logic [10:0] coarse;
  logic        is_hit;
  logic        coarse_ok;

  assign w      = item.data_word;
  assign wtype  = w[31:29];
  assign chan   = w[28:22];
  assign coarse = w[10:0];

  assign st_b         = item.first_word ? tbwu_pkg::PS_SEARCH : parse_state;
  assign pos_b        = item.first_word ? 8'd0  : word_position;
  assign left_b       = item.first_word ? 8'd0  : words_left;
  assign board_b      = item.first_word ? 2'd0  : current_board;
  assign epoch_b      = item.first_word ? 28'd0 : current_epoch;
  assign ref_epoch_b  = item.first_word ? 28'd0 : ref_epoch;
  assign ref_coarse_b = item.first_word ? 11'd0 : ref_coarse;
  assign err_b        = item.first_word ? 1'b0  : bank_error;

  assign is_hit = (st_b == tbwu_pkg::PS_BOARD) && (wtype == tbwu_pkg::WT_HIT);

  assign coarse_ok = (coarse == ref_coarse_b) ||
                     ({1'b0, coarse} + 12'd1 == {1'b0, ref_coarse_b}) ||
                     ({1'b0, coarse} == {1'b0, ref_coarse_b} + 12'd1);

  always_comb begin
    parse_state_next   = st_b;
    word_position_next = (pos_b != tbwu_pkg::POS_MAX) ? pos_b + 8'd1 : pos_b;
    words_left_next    = left_b;
    current_board_next = board_b;
    current_epoch_next = epoch_b;
    ref_epoch_next     = ref_epoch_b;
    ref_coarse_next    = ref_coarse_b;
    bank_error_next    = err_b;
    bank_count_next    = item.first_word ? bank_count + 32'd1 : bank_count;
    case (st_b)
      tbwu_pkg::PS_SEARCH: begin
        if (pos_b >= header_words) begin
          if (w[15:0] == tbwu_pkg::HDR_CTS) begin
            words_left_next  = w[23:16];
            parse_state_next = tbwu_pkg::PS_CTS;
          end else if ((w[15:0] & tbwu_pkg::HDR_BOARD_MSK) == tbwu_pkg::HDR_BOARD) begin
            current_board_next = w[1:0];
            words_left_next    = w[23:16];
            parse_state_next   = tbwu_pkg::PS_BOARD;
          end else if (w[15:0] == tbwu_pkg::HDR_END) begin
            parse_state_next = tbwu_pkg::PS_ENDED;
          end
        end
      end
      tbwu_pkg::PS_BOARD, tbwu_pkg::PS_CTS: begin
        if (st_b == tbwu_pkg::PS_BOARD && wtype == tbwu_pkg::WT_EPOCH) begin
          current_epoch_next = w[27:0];
        end
        if (is_hit && chan == 7'd0) begin
          if (ref_epoch_b == 28'd0) begin
            ref_epoch_next  = epoch_b;
            ref_coarse_next = coarse;
          end else if (epoch_b != ref_epoch_b || !coarse_ok) begin
            bank_error_next = 1'b1;
          end
        end
        if (left_b == 8'd1) begin
          parse_state_next = tbwu_pkg::PS_SEARCH;
        end else if (left_b != 8'd0) begin
          words_left_next = left_b - 8'd1;
        end
      end
      default: begin
      end
    endcase
  end

  tbwu_pkg::result_t hit_res, sum_res;

  always_comb begin
    hit_res             = '0;
    hit_res.kind        = tbwu_pkg::KIND_HIT;
    hit_res.board       = board_b;
    hit_res.channel     = chan;
    hit_res.epoch       = epoch_b;
    hit_res.fine_code   = w[20:12];
    hit_res.rise        = w[11];
    hit_res.coarse_code = coarse;
    hit_res.bank_number = bank_count_next;
    hit_res.last        = !item.last_word;

    sum_res                = '0;
    sum_res.kind           = tbwu_pkg::KIND_SUMMARY;
    sum_res.mismatch_error = bank_error_next;
    sum_res.sum_epoch      = ref_epoch_next;
    sum_res.sum_coarse     = ref_coarse_next;
    sum_res.bank_number    = bank_count_next;
    sum_res.last           = 1'b1;

    pair.count = {1'b0, is_hit} + {1'b0, item.last_word};
    pair.r0    = is_hit ? hit_res : sum_res;
    pair.r1    = sum_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state   <= tbwu_pkg::PS_SEARCH;
      word_position <= 8'd0;
      words_left    <= 8'd0;
      current_board <= 2'd0;
      current_epoch <= 28'd0;
      ref_epoch     <= 28'd0;
      ref_coarse    <= 11'd0;
      bank_error    <= 1'b0;
      bank_count    <= 32'd0;
    end else if (adv) begin
      parse_state   <= parse_state_next;
      word_position <= word_position_next;
      words_left    <= words_left_next;
      current_board <= current_board_next;
      current_epoch <= current_epoch_next;
      ref_epoch     <= ref_epoch_next;
      ref_coarse    <= ref_coarse_next;
      bank_error    <= bank_error_next;
      bank_count    <= bank_count_next;
    end
  end

endmodule

[rtl/tbwu_outq.sv]
// ----------------------------------------------------------------------------
// tbwu_outq
// Two-slot result queue. Loads a whole result pair when empty after this
// cycle's transfer, otherwise shifts toward the output.
// ----------------------------------------------------------------------------
module tbwu_outq (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  tbwu_pkg::result_pair_t pair,
  output logic                   room,
  output logic                   out_valid,
  input  logic                   out_ready,
  output tbwu_pkg::result_t      out_data
);

  tbwu_pkg::result_t q0, q1;
  logic [1:0] count;
  logic       pop;

  assign out_valid = (count != 2'd0);
  assign out_data  = q0;
  assign pop       = out_valid && out_ready;
  assign room      = (count == 2'd0) || (count == 2'd1 && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push) begin
      count <= pair.count;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q0 <= pair.r0;
      q1 <= pair.r1;
    end else if (pop) begin
      q0 <= q1;
    end
  end

endmodule

[rtl/tdc_bank_word_unpacker.sv]
// ----------------------------------------------------------------------------
// tdc_bank_word_unpacker
// Unpacks readout bank words into hit records and per-bank summaries.
// ----------------------------------------------------------------------------
// Data path: each word is registered in the input stage, advances once the
//   queue has room, and its results are registered in the queue for output.
// Throughput: one word per cycle while the output is ready; a word with both
//   a hit and a summary holds the input while the two-slot queue drains.
// Reset: parse state, counters and queue clear; header_words returns to 6.
module tdc_bank_word_unpacker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  tbwu_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tbwu_pkg::result_t  out_data,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_data
);

  logic [7:0]             header_words;
  tbwu_pkg::in_item_t     in_q;
  logic                   in_q_valid;
  logic                   room;
  logic                   adv;
  tbwu_pkg::result_pair_t pair;

  assign adv      = in_q_valid && room;
  assign in_ready = !in_q_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_words <= tbwu_pkg::HEADER_WORDS_RST;
    end else if (cfg_we) begin
      header_words <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_q_valid <= 1'b1;
    end else if (adv) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_data;
    end
  end

  tbwu_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .item         (in_q),
    .header_words (header_words),
    .pair         (pair)
  );

  tbwu_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (adv),
    .pair      (pair),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == tbwu_pkg::KIND_SUMMARY |-> out_data.last)
    else $error("summary result without last");

  a_hit_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == tbwu_pkg::KIND_HIT |->
      !out_data.mismatch_error && out_data.sum_epoch == 28'd0 &&
      out_data.sum_coarse == 11'd0)
    else $error("hit result carries summary fields");

  a_hold_word: assert property (@(posedge clk) disable iff (rst)
    in_q_valid && !room |=> in_q_valid && $stable(in_q))
    else $error("held word lost while queue full");

endmodule

[sim/tdc_bank_word_unpacker_tb.sv]
// ----------------------------------------------------------------------------
// tdc_bank_word_unpacker_tb
// Self-checking bench for the bank word unpacker. Readout banks are fed
// word by word, in most runs with random burst gaps on the input and a
// random stall pattern on the output. A local model of the parser predicts
// the hit records and bank summaries, and every transfer on the output side
// is checked field by field against the oldest prediction. Directed banks
// cover the header window, each subevent header, the epoch and hit words
// and the channel-0 reference check. Random banks follow, under several
// header window settings that include 0 and 255.
// ----------------------------------------------------------------------------
module tdc_bank_word_unpacker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum {RX_FREE, RX_RANDOM, RX_RUNS} rx_mode_t;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int MAX_REPORTS    = 40;

  logic               clk      = 1'b0;
  logic               rst      = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  tbwu_pkg::in_item_t in_data  = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  tbwu_pkg::result_t  out_data;
  logic               cfg_we   = 1'b0;
  logic [7:0]         cfg_data = '0;

  tdc_bank_word_unpacker u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  // parser model state
  tbwu_pkg::parse_state_t parse_st;
  logic [7:0]   word_pos;
  logic [7:0]   block_left;
  logic [7:0]   hdr_skip;
  logic [1:0]   board_id;
  logic [27:0]  epoch_now;
  logic [27:0]  evt_epoch;
  logic [10:0]  evt_coarse;
  logic         mis_flag;
  logic [31:0]  banks_seen;

  tbwu_pkg::result_t expected_records[$];
  int       fail_count  = 0;
  int       sent_items  = 0;
  int       idle_cycles = 0;
  int       burst_left  = 0;
  bit       tx_gaps     = 1'b0;
  rx_mode_t rx_mode     = RX_FREE;
  int       rx_run      = 0;
  bit       rx_stalled  = 1'b0;

  always #2 clk = ~clk;

  task automatic clear_bank_state();
    parse_st   = tbwu_pkg::PS_SEARCH;
    word_pos   = '0;
    block_left = '0;
    board_id   = '0;
    epoch_now  = '0;
    evt_epoch  = '0;
    evt_coarse = '0;
    mis_flag   = 1'b0;
  endtask

  task automatic step_block();
    if (block_left == 8'd1) begin
      parse_st = tbwu_pkg::PS_SEARCH;
    end else if (block_left != 8'd0) begin
      block_left = block_left - 8'd1;
    end
  endtask

  task automatic unpack_word(input tbwu_pkg::in_item_t it);
    logic [31:0]       w;
    logic [7:0]        pos;
    logic [6:0]        chan;
    logic [10:0]       coarse;
    tbwu_pkg::result_t hit;
    tbwu_pkg::result_t summary;
    bit                have_hit;
    w        = it.data_word;
    chan     = w[28:22];
    coarse   = w[10:0];
    hit      = '0;
    summary  = '0;
    have_hit = 1'b0;
    if (it.first_word) begin
      clear_bank_state();
      banks_seen = banks_seen + 32'd1;
    end
    pos = word_pos;
    if (word_pos != tbwu_pkg::POS_MAX) word_pos = word_pos + 8'd1;
    case (parse_st)
      tbwu_pkg::PS_SEARCH: begin
        if (pos >= hdr_skip) begin
          if (w[15:0] == tbwu_pkg::HDR_CTS) begin
            block_left = w[23:16];
            parse_st   = tbwu_pkg::PS_CTS;
          end else if ((w[15:0] & tbwu_pkg::HDR_BOARD_MSK) == tbwu_pkg::HDR_BOARD) begin
            board_id   = w[1:0];
            block_left = w[23:16];
            parse_st   = tbwu_pkg::PS_BOARD;
          end else if (w[15:0] == tbwu_pkg::HDR_END) begin
            parse_st = tbwu_pkg::PS_ENDED;
          end
        end
      end
      tbwu_pkg::PS_BOARD: begin
        if (w[31:29] == tbwu_pkg::WT_EPOCH) begin
          epoch_now = w[27:0];
        end else if (w[31:29] == tbwu_pkg::WT_HIT) begin
          have_hit            = 1'b1;
          hit.kind            = tbwu_pkg::KIND_HIT;
          hit.board           = board_id;
          hit.channel         = chan;
          hit.epoch           = epoch_now;
          hit.fine_code       = w[20:12];
          hit.rise            = w[11];
          hit.coarse_code     = coarse;
          hit.bank_number     = banks_seen;
          if (chan == 7'd0) begin
            if (evt_epoch == '0) begin
              evt_epoch  = epoch_now;
              evt_coarse = coarse;
            end else if (epoch_now != evt_epoch) begin
              mis_flag = 1'b1;
            end else if (coarse != evt_coarse &&
                         {1'b0, coarse} + 12'd1 != {1'b0, evt_coarse} &&
                         {1'b0, coarse} != {1'b0, evt_coarse} + 12'd1) begin
              mis_flag = 1'b1;
            end
          end
        end
        step_block();
      end
      tbwu_pkg::PS_CTS: step_block();
      default: ;
    endcase
    hit.last = !it.last_word;
    if (have_hit) expected_records.insert(expected_records.size(), hit);
    if (it.last_word) begin
      summary.kind           = tbwu_pkg::KIND_SUMMARY;
      summary.mismatch_error = mis_flag;
      summary.sum_epoch      = evt_epoch;
      summary.sum_coarse     = evt_coarse;
      summary.bank_number    = banks_seen;
      summary.last           = 1'b1;
      expected_records.insert(expected_records.size(), summary);
    end
  endtask

  // word builders
  function automatic logic [31:0] hit_word(logic [6:0] ch, logic [8:0] fine, logic re,
                                           logic [10:0] coarse);
    return {tbwu_pkg::WT_HIT, ch, 1'($urandom), fine, re, coarse};
  endfunction

  function automatic logic [31:0] epoch_word(logic [27:0] e);
    return {tbwu_pkg::WT_EPOCH, 1'($urandom), e};
  endfunction

  function automatic logic [31:0] board_header(logic [7:0] cnt, logic [1:0] id);
    return {8'($urandom), cnt, tbwu_pkg::HDR_BOARD | {14'd0, id}};
  endfunction

  function automatic logic [31:0] cts_header(logic [7:0] cnt);
    return {8'($urandom), cnt, tbwu_pkg::HDR_CTS};
  endfunction

  function automatic logic [31:0] end_marker();
    return {16'($urandom), tbwu_pkg::HDR_END};
  endfunction

  function automatic logic [31:0] block_content(logic [27:0] ep_base, logic [10:0] co_base);
    int          pick;
    logic [6:0]  ch;
    logic [10:0] co;
    logic [2:0]  t;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      return epoch_word(($urandom_range(0, 9) == 0) ? 28'($urandom) : ep_base);
    end else if (pick < 80) begin
      ch = ($urandom_range(0, 2) == 0) ? 7'd0 : 7'($urandom);
      co = co_base + 11'($urandom_range(0, 4)) - 11'd2;
      return hit_word(ch, 9'($urandom), 1'($urandom), co);
    end
    t = 3'($urandom_range(0, 5));
    if (t > 3'd2) t = t + 3'd2;
    return {t, 29'($urandom)};
  endfunction

  task automatic send_word(input logic [31:0] w, input logic first, input logic lastw);
    tbwu_pkg::in_item_t it;
    it.data_word  = w;
    it.first_word = first;
    it.last_word  = lastw;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    unpack_word(it);
    sent_items++;
    if (tx_gaps) begin
      if (burst_left == 0) begin
        repeat ($urandom_range(1, 8)) begin
          @(negedge clk);
          in_valid <= 1'b0;
        end
        burst_left = $urandom_range(1, 16);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic drain_outputs();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_records.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_header_words(input logic [7:0] v);
    drain_outputs();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we   <= 1'b0;
    hdr_skip = v;
  endtask

  task automatic send_bank();
    logic [27:0] ep_base;
    logic [10:0] co_base;
    int          fillers;
    int          n_sub;
    int          pick;
    int          cnt;
    int          s;
    bit          open_block;
    ep_base = ($urandom_range(0, 7) == 0) ? 28'd0 : 28'($urandom);
    co_base = 11'($urandom);
    if ($urandom_range(0, 19) == 0) begin
      send_word($urandom, 1'b1, 1'b1);
      return;
    end
    send_word($urandom, 1'b1, 1'b0);
    fillers = (hdr_skip == 8'd0) ? 0 : int'(hdr_skip) - 1;
    if ($urandom_range(0, 9) == 0) fillers = fillers + $urandom_range(0, 4) - 2;
    if (fillers < 0) fillers = 0;
    repeat (fillers) send_word($urandom, 1'b0, 1'b0);
    n_sub      = $urandom_range(1, 4);
    open_block = 1'b0;
    for (s = 0; s < n_sub && !open_block; s++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        cnt = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
        send_word(cts_header(8'(cnt)), 1'b0, 1'b0);
        if (cnt == 0) begin
          open_block = 1'b1;
          cnt = $urandom_range(1, 4);
        end
        repeat (cnt) send_word($urandom, 1'b0, 1'b0);
      end else if (pick < 25) begin
        send_word(end_marker(), 1'b0, 1'b0);
        repeat ($urandom_range(0, 3)) send_word(block_content(ep_base, co_base), 1'b0, 1'b0);
        open_block = 1'b1;
      end else begin
        cnt = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
        send_word(board_header(8'(cnt), 2'($urandom)), 1'b0, 1'b0);
        if (cnt == 0) begin
          open_block = 1'b1;
          cnt = $urandom_range(1, 10);
        end else if ($urandom_range(0, 9) == 0) begin
          cnt = cnt + $urandom_range(0, 2) - 1;
        end
        repeat (cnt) send_word(block_content(ep_base, co_base), 1'b0, 1'b0);
      end
    end
    if ($urandom_range(0, 9) != 0)
      send_word($urandom_range(0, 1) ? block_content(ep_base, co_base) : $urandom,
                1'b0, 1'b1);
  endtask

  task automatic test_header_window();
    send_word(hit_word(7'd0, 9'h001, 1'b1, 11'h001), 1'b0, 1'b1);
    send_word(board_header(8'd5, 2'd0), 1'b1, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0, 1'b0);
    send_word(cts_header(8'd3), 1'b0, 1'b0);
    send_word(end_marker(), 1'b0, 1'b0);
    send_word(32'h0000_0000, 1'b0, 1'b0);
    send_word(board_header(8'd3, 2'd1), 1'b0, 1'b0);
    send_word(board_header(8'd5, 2'd2), 1'b0, 1'b0);
    send_word(epoch_word(28'hFFF_FFFF), 1'b0, 1'b0);
    send_word(hit_word(7'd0, 9'h1FF, 1'b1, 11'h7FF), 1'b0, 1'b0);
    send_word(hit_word(7'd0, 9'h1FF, 1'b0, 11'h7FE), 1'b0, 1'b0);
    send_word(hit_word(7'd127, 9'h000, 1'b0, 11'h000), 1'b0, 1'b0);
    send_word(32'h0000_0000, 1'b0, 1'b0);
    send_word(cts_header(8'd1), 1'b0, 1'b0);
    send_word(board_header(8'd1, 2'd0), 1'b0, 1'b0);
    send_word(board_header(8'd0, 2'd3), 1'b0, 1'b0);
    send_word(epoch_word(28'd5), 1'b0, 1'b0);
    send_word(hit_word(7'd0, 9'h000, 1'b1, 11'h010), 1'b0, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0, 1'b1);
  endtask

  task automatic test_zero_header();
    write_header_words(8'd0);
    send_word(board_header(8'd0, 2'd1), 1'b1, 1'b1);
    send_word(board_header(8'd1, 2'd0), 1'b1, 1'b0);
    send_word(hit_word(7'd0, 9'h0AA, 1'b1, 11'h005), 1'b0, 1'b0);
    send_word(end_marker(), 1'b0, 1'b0);
    send_word(board_header(8'd2, 2'd0), 1'b0, 1'b0);
    send_word(hit_word(7'd0, 9'h155, 1'b0, 11'h2AA), 1'b0, 1'b1);
    send_word(board_header(8'd0, 2'd0), 1'b1, 1'b0);
    send_word(epoch_word(28'd9), 1'b0, 1'b0);
    send_word(hit_word(7'd0, 9'h000, 1'b1, 11'h100), 1'b0, 1'b0);
    send_word(hit_word(7'd0, 9'h000, 1'b0, 11'h102), 1'b0, 1'b1);
  endtask

  task automatic test_random_banks(input logic [7:0] hdr, input int n_items,
                                   input rx_mode_t rx, input bit gaps);
    int start;
    write_header_words(hdr);
    rx_mode    = rx;
    tx_gaps    = gaps;
    burst_left = 0;
    start      = sent_items;
    while (sent_items - start < n_items) begin
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 4)) send_word($urandom, 1'b0, 1'b0);
      send_bank();
    end
  endtask

  task automatic test_noise_words(input int n_items);
    rx_mode = RX_RANDOM;
    tx_gaps = 1'b1;
    repeat (n_items)
      send_word($urandom, $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  task automatic check_record(input tbwu_pkg::result_t got);
    tbwu_pkg::result_t want;
    if (expected_records.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: record with none expected, expected none actual %h", $time, got);
      return;
    end
    want = expected_records.pop_front();
    compare_field("kind", want.kind, got.kind);
    compare_field("board", want.board, got.board);
    compare_field("channel", want.channel, got.channel);
    compare_field("epoch", want.epoch, got.epoch);
    compare_field("fine_code", want.fine_code, got.fine_code);
    compare_field("rise", want.rise, got.rise);
    compare_field("coarse_code", want.coarse_code, got.coarse_code);
    compare_field("mismatch_error", want.mismatch_error, got.mismatch_error);
    compare_field("sum_epoch", want.sum_epoch, got.sum_epoch);
    compare_field("sum_coarse", want.sum_coarse, got.sum_coarse);
    compare_field("bank_number", want.bank_number, got.bank_number);
    compare_field("last", want.last, got.last);
  endtask

  always @(negedge clk) begin
    case (rx_mode)
      RX_FREE:   out_ready <= 1'b1;
      RX_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (rx_run == 0) begin
          rx_stalled = !rx_stalled;
          rx_run     = $urandom_range(1, 10);
        end else begin
          rx_run--;
        end
        out_ready <= !rx_stalled;
      end
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) check_record(out_data);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[tdc_bank_word_unpacker] ERROR");
      $finish;
    end
  end

  initial begin
    clear_bank_state();
    hdr_skip   = tbwu_pkg::HEADER_WORDS_RST;
    banks_seen = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_header_window();
    test_zero_header();
    test_random_banks(8'd6, 180, RX_FREE, 1'b0);
    test_random_banks(8'd0, 180, RX_RANDOM, 1'b1);
    test_random_banks(8'd1, 140, RX_RUNS, 1'b1);
    test_random_banks(8'd255, 250, RX_RANDOM, 1'b1);
    test_random_banks(8'($urandom_range(2, 16)), 180, RX_RUNS, 1'b0);
    test_noise_words(100);
    test_random_banks(8'd3, 140, RX_RANDOM, 1'b1);
    drain_outputs();
    if (fail_count == 0) begin
      $display("[tdc_bank_word_unpacker] OK");
    end else begin
      $display("[tdc_bank_word_unpacker] ERROR");
    end
    $finish;
  end

endmodule
